// ===== sv/next_lexicographic_permutation_core_defines.svh =====
// assertion macros for the next lexicographic permutation core
// included by the top level, no other dependencies
`ifndef NEXT_LEXICOGRAPHIC_PERMUTATION_CORE_DEFINES_SVH
`define NEXT_LEXICOGRAPHIC_PERMUTATION_CORE_DEFINES_SVH
`ifndef NO_ASSERTIONS
// combinational property checked on every rising clock edge outside reset
`define NLP_ASSERT(lbl, clk, rst_n, expr) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (expr)) \
    else $error("nlp assertion failed");
// implication whose consequent is checked in the cycle after the antecedent
`define NLP_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("nlp assertion failed");
`else
`define NLP_ASSERT(lbl, clk, rst_n, expr)
`define NLP_ASSERT_NEXT(lbl, clk, rst_n, ante, cons)
`endif
`endif

// ===== sv/nlp_pkg.sv =====
// shared types and constants of the next lexicographic permutation core
// no dependencies
package nlp_pkg;

  // field widths fixed by the interface
  localparam int POS_W    = 4;
  localparam int IN_VAL_W = 16;
  localparam int COUNT_W  = 5;
  localparam int CFG_AW   = 3;
  localparam int CFG_DW   = 32;

  localparam logic [COUNT_W-1:0] COUNT_RESET = 5'd16;

  // register index of element_count, taken from paddr[2]
  localparam logic REG_ELEMENT_COUNT = 1'b0;

  typedef enum logic [0:0] {
    OP_LOAD    = 1'b0,
    OP_ADVANCE = 1'b1
  } opcode_t;

endpackage

// ===== sv/nlp_ram.sv =====
// generic single write port, single read port ram with registered read
// no dependencies
module nlp_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write and registered read
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== sv/next_lexicographic_permutation_core.sv =====
// top level of the next lexicographic permutation core
// depends on nlp_pkg, nlp_ram and next_lexicographic_permutation_core_defines.svh
//
//   channel | signals                                          | direction
//   in      | in_valid/in_ready, in_opcode, in_position, value  | item in
//   out     | out_valid/out_ready, position, value, flags      | one beat per element
//   cfg     | psel/penable/pwrite/paddr/pwdata/prdata/pready   | register access
//
// a load is written to the store as it is accepted and leaves in_ready high
// an advance runs the pivot scan, the successor scan, the pivot swap, the suffix swaps
// and the result stream in turn, sharing the single ram read port; stalls on out_ready
// hold the result stream
// no clearing pass: the store holds garbage until loaded
// reset is synchronous, active low, clears control state and sets element_count to 16
`include "next_lexicographic_permutation_core_defines.svh"
module next_lexicographic_permutation_core #(
  parameter int MAX_ELEMS   = 16,
  parameter int VALUE_WIDTH = 16
) (
  input  logic                          clk,
  input  logic                          rst_n,
  // input beats
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic                          in_opcode,
  input  logic [nlp_pkg::POS_W-1:0]     in_position,
  input  logic signed [nlp_pkg::IN_VAL_W-1:0] in_element_value,
  // result beats
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [nlp_pkg::POS_W-1:0]     out_position,
  output logic signed [nlp_pkg::IN_VAL_W-1:0] out_value,
  output logic                          out_advanced,
  output logic                          out_last_of_run,
  // configuration
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [nlp_pkg::CFG_AW-1:0]    paddr,
  input  logic [nlp_pkg::CFG_DW-1:0]    pwdata,
  output logic [nlp_pkg::CFG_DW-1:0]    prdata,
  output logic                          pready
);

  import nlp_pkg::*;

  localparam int AW = $clog2(MAX_ELEMS);
  localparam int NW = ($clog2(MAX_ELEMS + 1) > COUNT_W) ? $clog2(MAX_ELEMS + 1) : COUNT_W;

  typedef enum logic [3:0] {
    S_IDLE,
    S_PRD,
    S_PCMP,
    S_SRD,
    S_SCMP,
    S_SW1,
    S_SW2,
    S_RRD1,
    S_RRD2,
    S_RWR1,
    S_RWR2,
    S_ORD,
    S_OCAP,
    S_OWAIT
  } state_t;

  state_t                 state_r, state_nxt;
  logic [COUNT_W-1:0]     count_r;
  logic [AW-1:0]          idx_r, idx_nxt;
  logic [AW-1:0]          k_r, k_nxt;
  logic [AW-1:0]          j_r, j_nxt;
  logic [AW-1:0]          last_r, last_nxt;
  logic                   first_r, first_nxt;
  logic                   adv_r, adv_nxt;
  logic [VALUE_WIDTH-1:0] prev_r, prev_nxt;
  logic [VALUE_WIDTH-1:0] pv_r, pv_nxt;
  logic [VALUE_WIDTH-1:0] tmp_r, tmp_nxt;
  logic                   out_valid_r, out_valid_nxt;
  logic [AW-1:0]          out_pos_r, out_pos_nxt;
  logic [IN_VAL_W-1:0]    out_value_r, out_value_nxt;
  logic                   out_last_r, out_last_nxt;

  logic                   ram_we;
  logic [AW-1:0]          ram_waddr;
  logic [VALUE_WIDTH-1:0] ram_wdata;
  logic [AW-1:0]          ram_raddr;
  logic [VALUE_WIDTH-1:0] ram_rdata;

  logic [NW-1:0]          n_act;
  logic                   pos_ok;
  logic                   in_fire;
  logic                   cfg_wr;
  logic [VALUE_WIDTH-1:0] cmp_x, cmp_y;
  logic                   cmp_lt;

  nlp_ram #(
    .WIDTH (VALUE_WIDTH),
    .DEPTH (MAX_ELEMS)
  ) u_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // configuration port
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && (paddr[2] == REG_ELEMENT_COUNT);
  assign prdata = (paddr[2] == REG_ELEMENT_COUNT) ? CFG_DW'(count_r) : '0;

  // handshake
  assign in_ready = (state_r == S_IDLE);
  assign in_fire  = in_valid && in_ready;
  assign pos_ok   = int'(in_position) < MAX_ELEMS;

  // active element count, clamped to 1..MAX_ELEMS
  always_comb begin
    n_act = NW'(count_r);
    if (n_act == '0) begin
      n_act = NW'(1);
    end else if (n_act > NW'(MAX_ELEMS)) begin
      n_act = NW'(MAX_ELEMS);
    end
  end

  // shared signed compare unit: key(x) < key(y)
  always_comb begin
    if (state_r == S_SCMP) begin
      cmp_x = pv_r;
      cmp_y = ram_rdata;
    end else begin
      cmp_x = ram_rdata;
      cmp_y = prev_r;
    end
  end
  assign cmp_lt = {~cmp_x[VALUE_WIDTH-1], cmp_x[VALUE_WIDTH-2:0]} <
                  {~cmp_y[VALUE_WIDTH-1], cmp_y[VALUE_WIDTH-2:0]};

  // ram port selection
  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = idx_r;
    ram_wdata = tmp_r;
    ram_raddr = idx_r;
    unique case (state_r)
      S_IDLE: begin
        ram_we    = in_fire && (in_opcode == OP_LOAD) && pos_ok;
        ram_waddr = AW'(in_position);
        ram_wdata = VALUE_WIDTH'(in_element_value);
      end
      S_SRD:  ram_raddr = k_r;
      S_RRD2: ram_raddr = k_r;
      S_SW1: begin
        ram_we    = 1'b1;
        ram_waddr = j_r;
        ram_wdata = tmp_r;
      end
      S_SW2: begin
        ram_we    = 1'b1;
        ram_waddr = k_r;
        ram_wdata = pv_r;
      end
      S_RWR1: begin
        ram_we    = 1'b1;
        ram_waddr = idx_r;
        ram_wdata = ram_rdata;
      end
      S_RWR2: begin
        ram_we    = 1'b1;
        ram_waddr = k_r;
        ram_wdata = tmp_r;
      end
      // prefetch the next element while the current beat waits
      S_OWAIT: ram_raddr = out_last_r ? idx_r : idx_r + AW'(1);
      default: ram_raddr = idx_r;
    endcase
  end

  // sequencer next state
  always_comb begin
    state_nxt     = state_r;
    idx_nxt       = idx_r;
    k_nxt         = k_r;
    j_nxt         = j_r;
    last_nxt      = last_r;
    first_nxt     = first_r;
    adv_nxt       = adv_r;
    prev_nxt      = prev_r;
    pv_nxt        = pv_r;
    tmp_nxt       = tmp_r;
    out_valid_nxt = out_valid_r;
    out_pos_nxt   = out_pos_r;
    out_value_nxt = out_value_r;
    out_last_nxt  = out_last_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_fire && (in_opcode == OP_ADVANCE)) begin
          last_nxt  = AW'(n_act - NW'(1));
          first_nxt = 1'b1;
          if (n_act < NW'(2)) begin
            adv_nxt   = 1'b0;
            idx_nxt   = '0;
            state_nxt = S_ORD;
          end else begin
            idx_nxt   = AW'(n_act - NW'(1));
            state_nxt = S_PRD;
          end
        end
      end
      // pivot scan from the right
      S_PRD: state_nxt = S_PCMP;
      S_PCMP: begin
        if (first_r) begin
          first_nxt = 1'b0;
          prev_nxt  = ram_rdata;
          idx_nxt   = idx_r - AW'(1);
          state_nxt = S_PRD;
        end else if (cmp_lt) begin
          j_nxt     = idx_r;
          pv_nxt    = ram_rdata;
          k_nxt     = last_r;
          state_nxt = S_SRD;
        end else if (idx_r == '0) begin
          adv_nxt   = 1'b0;
          state_nxt = S_ORD;
        end else begin
          prev_nxt  = ram_rdata;
          idx_nxt   = idx_r - AW'(1);
          state_nxt = S_PRD;
        end
      end
      // rightmost element larger than the pivot
      S_SRD: state_nxt = S_SCMP;
      S_SCMP: begin
        if (cmp_lt) begin
          tmp_nxt   = ram_rdata;
          state_nxt = S_SW1;
        end else begin
          k_nxt     = k_r - AW'(1);
          state_nxt = S_SRD;
        end
      end
      S_SW1: state_nxt = S_SW2;
      S_SW2: begin
        adv_nxt = 1'b1;
        if ((AW + 1)'(j_r) + (AW + 1)'(1) < (AW + 1)'(last_r)) begin
          idx_nxt   = j_r + AW'(1);
          k_nxt     = last_r;
          state_nxt = S_RRD1;
        end else begin
          idx_nxt   = '0;
          state_nxt = S_ORD;
        end
      end
      // suffix reversal, one swap per pass
      S_RRD1: state_nxt = S_RRD2;
      S_RRD2: begin
        tmp_nxt   = ram_rdata;
        state_nxt = S_RWR1;
      end
      S_RWR1: state_nxt = S_RWR2;
      S_RWR2: begin
        if ((AW + 1)'(idx_r) + (AW + 1)'(2) < (AW + 1)'(k_r)) begin
          idx_nxt   = idx_r + AW'(1);
          k_nxt     = k_r - AW'(1);
          state_nxt = S_RRD1;
        end else begin
          idx_nxt   = '0;
          state_nxt = S_ORD;
        end
      end
      // result stream
      S_ORD: state_nxt = S_OCAP;
      S_OCAP: begin
        out_valid_nxt = 1'b1;
        out_pos_nxt   = idx_r;
        out_value_nxt = IN_VAL_W'(ram_rdata);
        out_last_nxt  = (idx_r == last_r);
        state_nxt     = S_OWAIT;
      end
      S_OWAIT: begin
        if (out_ready) begin
          out_valid_nxt = 1'b0;
          if (out_last_r) begin
            state_nxt = S_IDLE;
          end else begin
            idx_nxt   = idx_r + AW'(1);
            state_nxt = S_OCAP;
          end
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // state, control and registered outputs
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= COUNT_RESET;
      out_valid_r <= 1'b0;
      first_r     <= 1'b0;
      adv_r       <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      first_r     <= first_nxt;
      adv_r       <= adv_nxt;
      if (cfg_wr) begin
        count_r <= pwdata[COUNT_W-1:0];
      end
    end
    idx_r       <= idx_nxt;
    k_r         <= k_nxt;
    j_r         <= j_nxt;
    last_r      <= last_nxt;
    prev_r      <= prev_nxt;
    pv_r        <= pv_nxt;
    tmp_r       <= tmp_nxt;
    out_pos_r   <= out_pos_nxt;
    out_value_r <= out_value_nxt;
    out_last_r  <= out_last_nxt;
  end

  assign out_valid       = out_valid_r;
  assign out_position    = POS_W'(out_pos_r);
  assign out_value       = out_value_r;
  assign out_advanced    = adv_r;
  assign out_last_of_run = out_last_r;

  // checks
  `NLP_ASSERT(a_no_input_while_result, clk, rst_n, !(in_ready && out_valid))
  `NLP_ASSERT_NEXT(a_advance_blocks_input, clk, rst_n,
                   in_valid && in_ready && (in_opcode == OP_ADVANCE), !in_ready)
  `NLP_ASSERT_NEXT(a_last_beat_frees_input, clk, rst_n,
                   out_valid && out_ready && out_last_of_run, in_ready)
  `NLP_ASSERT(a_last_beat_position, clk, rst_n,
              !(out_valid && out_last_of_run) || (out_pos_r == last_r))
  `NLP_ASSERT_NEXT(a_flag_steady_in_run, clk, rst_n,
                   out_valid && out_ready && !out_last_of_run, $stable(adv_r))

endmodule

// ===== tb/tb_next_lexicographic_permutation_core.sv =====
// self-checking testbench for next_lexicographic_permutation_core
// depends on nlp_pkg and the core rtl; predicts every element beat in place
// runs directed loads and advances, then random sequences under four stall mixes
module tb_next_lexicographic_permutation_core;
  timeunit 1ns;
  timeprecision 1ps;
  import nlp_pkg::*;

  localparam int ELEMS            = 16;
  localparam int VAL_W            = 16;
  localparam int SETTLE_CYCLES    = 200;
  localparam int WATCHDOG_LIMIT   = 4000;
  localparam int SHOWN_MISMATCHES = 10;
  localparam int SEGMENT_ITEMS    = 28;
  localparam logic [CFG_AW-1:0] COUNT_ADDR = CFG_AW'({REG_ELEMENT_COUNT, 2'b00});

  typedef struct {
    opcode_t                     op;
    logic [POS_W-1:0]            pos;
    logic signed [IN_VAL_W-1:0]  value;
  } perm_cmd_t;

  typedef struct {
    logic [POS_W-1:0]            pos;
    logic signed [VAL_W-1:0]     value;
    logic                        advanced;
    logic                        last;
  } elem_beat_t;

  logic                        clk = 1'b0;
  logic                        rst_n = 1'b0;
  logic                        in_valid = 1'b0;
  logic                        in_ready;
  logic                        in_opcode = 1'b0;
  logic [POS_W-1:0]            in_position = '0;
  logic signed [IN_VAL_W-1:0]  in_element_value = '0;
  logic                        out_valid;
  logic                        out_ready = 1'b0;
  logic [POS_W-1:0]            out_position;
  logic signed [IN_VAL_W-1:0]  out_value;
  logic                        out_advanced;
  logic                        out_last_of_run;
  logic                        psel = 1'b0;
  logic                        penable = 1'b0;
  logic                        pwrite = 1'b0;
  logic [CFG_AW-1:0]           paddr = '0;
  logic [CFG_DW-1:0]           pwdata = '0;
  logic [CFG_DW-1:0]           prdata;
  logic                        pready;

  // commands waiting to be driven and element beats waiting to come out
  perm_cmd_t                   cmd_queue[$];
  elem_beat_t                  expected_elems[$];

  // predicted array contents and element_count register
  logic signed [VAL_W-1:0]     perm_model [ELEMS];
  logic [COUNT_W-1:0]          elem_count = COUNT_RESET;

  // generator side record of which positions hold a loaded value
  bit [ELEMS-1:0]              loaded_mask = '0;

  logic                        in_taken = 1'b0;
  int                          idle_pct = 0;
  int                          stall_pct = 0;
  int                          idle_cycles = 0;
  int                          mismatches = 0;
  int                          loads_seen = 0;
  int                          advances_seen = 0;
  int                          beats_seen = 0;
  int                          cfg_writes = 0;

  // per phase pressure and per segment count settings, -1 picks at random
  int send_plan  [4] = '{0, 85, 0, 37};
  int stall_plan [4] = '{0, 0, 85, 37};
  int count_plan [12] = '{1, 5, 16, 0, 2, -1, 31, 3, -1, 17, 4, -1};

  next_lexicographic_permutation_core #(
    .MAX_ELEMS   (ELEMS),
    .VALUE_WIDTH (VAL_W)
  ) uut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_opcode        (in_opcode),
    .in_position      (in_position),
    .in_element_value (in_element_value),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_position     (out_position),
    .out_value        (out_value),
    .out_advanced     (out_advanced),
    .out_last_of_run  (out_last_of_run),
    .psel             (psel),
    .penable          (penable),
    .pwrite           (pwrite),
    .paddr            (paddr),
    .pwdata           (pwdata),
    .prdata           (prdata),
    .pready           (pready)
  );

  // 20 ns clock
  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // number of elements taking part for a given register value
  function automatic int active_elems(logic [COUNT_W-1:0] cnt);
    if (cnt == 0) return 1;
    if (cnt > ELEMS) return ELEMS;
    return int'(cnt);
  endfunction

  // rearrange the first n predicted elements into the next permutation
  function automatic bit permute_next(int n);
    int pivot, succ, lo, hi;
    logic signed [VAL_W-1:0] tmp;
    if (n < 2) return 1'b0;
    pivot = n - 1;
    while (pivot > 0 && perm_model[pivot-1] >= perm_model[pivot]) pivot--;
    if (pivot == 0) return 1'b0;
    pivot--;
    succ = n - 1;
    while (perm_model[succ] <= perm_model[pivot]) succ--;
    tmp = perm_model[pivot];
    perm_model[pivot] = perm_model[succ];
    perm_model[succ] = tmp;
    // reverse the suffix after the pivot
    lo = pivot + 1;
    hi = n - 1;
    while (hi > lo) begin
      tmp = perm_model[lo];
      perm_model[lo] = perm_model[hi];
      perm_model[hi] = tmp;
      lo++;
      hi--;
    end
    return 1'b1;
  endfunction

  function automatic void note_mismatch(string msg);
    mismatches++;
    if (mismatches <= SHOWN_MISMATCHES) $display("%s", msg);
  endfunction

  function automatic bit prefix_loaded(int n);
    for (int i = 0; i < n; i++) begin
      if (!loaded_mask[i]) return 1'b0;
    end
    return 1'b1;
  endfunction

  // mix of full range values, a narrow pool for repeats, and the extremes
  function automatic logic signed [VAL_W-1:0] pick_value();
    case ($urandom_range(0, 3))
      0, 1: return VAL_W'($urandom);
      2: return VAL_W'($urandom_range(0, 4) - 2);
      default: begin
        case ($urandom_range(0, 3))
          0: return 16'sh8000;
          1: return 16'sh7fff;
          2: return 16'sh0000;
          default: return 16'shffff;
        endcase
      end
    endcase
  endfunction

  function automatic void push_load(logic [POS_W-1:0] pos, logic signed [IN_VAL_W-1:0] value);
    perm_cmd_t cmd;
    cmd.op = OP_LOAD;
    cmd.pos = pos;
    cmd.value = value;
    if (pos < ELEMS) loaded_mask[pos] = 1'b1;
    cmd_queue.push_back(cmd);
  endfunction

  // position and value ride along with random bits, the core ignores them
  function automatic void push_advance();
    perm_cmd_t cmd;
    cmd.op = OP_ADVANCE;
    cmd.pos = POS_W'($urandom);
    cmd.value = IN_VAL_W'($urandom);
    cmd_queue.push_back(cmd);
  endfunction

  // random sequences: full reloads with a run of advances, partial reloads, noise
  function automatic void gen_items(int n, int budget);
    int used, r, k, cnt;
    bit rev;
    used = 0;
    while (used < budget) begin
      r = $urandom_range(0, 9);
      if (r < 7 || !prefix_loaded(n)) begin
        rev = $urandom_range(0, 1);
        for (int i = 0; i < n; i++) push_load(POS_W'(rev ? n - 1 - i : i), pick_value());
        k = (n <= 3) ? $urandom_range(2, 7) : $urandom_range(1, 4);
        repeat (k) push_advance();
        used += n + k;
      end else if (r < 9) begin
        cnt = $urandom_range(1, 3);
        repeat (cnt) push_load(POS_W'($urandom_range(0, n - 1)), pick_value());
        push_advance();
        used += cnt + 1;
      end else begin
        if ($urandom_range(0, 1)) push_load(POS_W'($urandom_range(0, ELEMS - 1)), pick_value());
        else push_advance();
        used++;
      end
    end
  endfunction

  // wait until every command is taken, every beat is back, and the core is quiet
  task automatic wait_drained();
    while (cmd_queue.size() != 0 || in_valid) @(posedge clk);
    while (expected_elems.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // apb write of element_count with random upper bits, then read it back
  task automatic set_element_count(logic [COUNT_W-1:0] cnt);
    logic [CFG_DW-1:0] word;
    word = $urandom;
    word[COUNT_W-1:0] = cnt;
    @(negedge clk);
    psel <= 1'b1;
    pwrite <= 1'b1;
    paddr <= COUNT_ADDR;
    pwdata <= word;
    penable <= 1'b0;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    elem_count = cnt;
    cfg_writes++;
    @(negedge clk);
    pwrite <= 1'b0;
    penable <= 1'b0;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    if (prdata[COUNT_W-1:0] !== cnt) begin
      note_mismatch($sformatf("element_count readback: expected %0d, got %0d",
                              cnt, prdata[COUNT_W-1:0]));
    end
    @(negedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
  endtask

  // input driver and receiver stalls, both change on the falling edge
  always @(negedge clk) begin : drive_inputs
    perm_cmd_t nxt;
    if (!rst_n) begin
      in_valid <= 1'b0;
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(0, 99) >= stall_pct);
      // a beat stays put until it is taken
      if (!in_valid || in_taken) begin
        if (cmd_queue.size() != 0 && $urandom_range(0, 99) >= idle_pct) begin
          nxt = cmd_queue.pop_front();
          in_valid <= 1'b1;
          in_opcode <= nxt.op;
          in_position <= nxt.pos;
          in_element_value <= nxt.value;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // predict on accepted commands, check result beats, watch for a hang
  always @(posedge clk) begin : check_outputs
    elem_beat_t want;
    int n;
    bit adv;
    if (!rst_n) begin
      in_taken <= 1'b0;
      idle_cycles = 0;
    end else begin
      in_taken <= in_valid && in_ready;
      if (in_valid && in_ready) begin
        if (opcode_t'(in_opcode) == OP_LOAD) begin
          if (in_position < ELEMS) perm_model[in_position] = in_element_value;
          loads_seen++;
        end else begin
          n = active_elems(elem_count);
          adv = permute_next(n);
          for (int i = 0; i < n; i++) begin
            want.pos = POS_W'(i);
            want.value = perm_model[i];
            want.advanced = adv;
            want.last = (i == n - 1);
            expected_elems.push_back(want);
          end
          advances_seen++;
        end
      end
      if (out_valid && out_ready) begin
        beats_seen++;
        if (expected_elems.size() == 0) begin
          note_mismatch($sformatf("unexpected element beat: pos %0d value %0d adv %0b last %0b",
                                  out_position, out_value, out_advanced, out_last_of_run));
        end else begin
          want = expected_elems.pop_front();
          if (out_position !== want.pos || out_value !== want.value ||
              out_advanced !== want.advanced || out_last_of_run !== want.last) begin
            note_mismatch($sformatf({"element beat mismatch: expected pos %0d value %0d ",
                                     "adv %0b last %0b, got pos %0d value %0d adv %0b last %0b"},
                                    want.pos, want.value, want.advanced, want.last,
                                    out_position, out_value, out_advanced, out_last_of_run));
          end
        end
      end
      // watchdog on cycles without any handshake
      if ((in_valid && in_ready) || (out_valid && out_ready) || (psel && penable)) begin
        idle_cycles = 0;
      end else begin
        idle_cycles++;
      end
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("watchdog expired with %0d commands and %0d beats outstanding",
                 cmd_queue.size(), expected_elems.size());
        $display("simulation failed");
        $finish;
      end
    end
  end

  // stimulus sequence
  initial begin : run_test
    int cnt;
    for (int i = 0; i < ELEMS; i++) perm_model[i] = '0;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // three distinct extremes walked through all six orders, the last one stays
    set_element_count(5'd3);
    push_load(4'd0, 16'sh8000);
    push_load(4'd1, 16'sh0000);
    push_load(4'd2, 16'sh7fff);
    repeat (6) push_advance();
    // repeated values handled as a multiset
    push_load(4'd0, 16'shffff);
    push_load(4'd1, 16'shffff);
    push_load(4'd2, 16'sh0005);
    repeat (3) push_advance();
    // top position, outside the active range
    push_load(4'd15, 16'shfffe);
    wait_drained();
    // zero count acts as a single element, never advances
    set_element_count(5'd0);
    push_advance();
    wait_drained();
    // two elements: one advance, then already last
    set_element_count(5'd2);
    push_load(4'd0, 16'sh8000);
    push_load(4'd1, 16'sh0000);
    repeat (2) push_advance();

    // random part, three count settings under each pressure mix
    for (int ph = 0; ph < 4; ph++) begin
      for (int sg = 0; sg < 3; sg++) begin
        wait_drained();
        idle_pct = send_plan[ph];
        stall_pct = stall_plan[ph];
        cnt = count_plan[ph * 3 + sg];
        if (cnt < 0) cnt = $urandom_range(1, ELEMS);
        set_element_count(COUNT_W'(cnt));
        gen_items(active_elems(COUNT_W'(cnt)), SEGMENT_ITEMS);
      end
    end
    wait_drained();

    if (expected_elems.size() != 0) begin
      note_mismatch($sformatf("%0d element beats never arrived", expected_elems.size()));
    end
    $display("covered %0d loads and %0d advances, %0d element beats compared",
             loads_seen, advances_seen, beats_seen);
    $display("%0d element_count writes across four stall mixes, %0d mismatches",
             cfg_writes, mismatches);
    if (mismatches == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

// ===== next_lexicographic_permutation_core.f =====
+incdir+sv
sv/nlp_pkg.sv
sv/nlp_ram.sv
sv/next_lexicographic_permutation_core.sv
tb/tb_next_lexicographic_permutation_core.sv
